// ----- sv/ecmt_pkg.sv -----
// ----------------------------------------------------------------------------
// ecmt_pkg
// Request codes, result status codes and controller states of the entity
// component mask table.
// ----------------------------------------------------------------------------
package ecmt_pkg;

  typedef enum logic [2:0] {
    REQ_CREATE = 3'd0,
    REQ_KILL   = 3'd1,
    REQ_ADD    = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_HAS    = 3'd4,
    REQ_QUERY  = 3'd5
  } req_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BADID = 2'd2
  } status_e_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_QRD,
    S_QEVAL,
    S_QEND
  } state_e_t;

endpackage

// ----- sv/ecmt_ifs.sv -----
// ----------------------------------------------------------------------------
// ecmt request and response channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface ecmt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [5:0]  entity_id;
  logic [4:0]  component_id;
  logic [31:0] query_mask;

  modport source (output valid, req_type, entity_id, component_id, query_mask,
                  input ready);
  modport sink   (input valid, req_type, entity_id, component_id, query_mask,
                  output ready);
endinterface

interface ecmt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] result_id;
  logic       has_component;
  logic       match_found;
  logic [6:0] ids_issued;
  logic       last;

  modport source (output valid, status, result_id, has_component, match_found,
                  ids_issued, last, input ready);
  modport sink   (input valid, status, result_id, has_component, match_found,
                  ids_issued, last, output ready);
endinterface

// ----- sv/entity_component_mask_table.sv -----
// ----------------------------------------------------------------------------
// entity_component_mask_table
// Entity id table with alive flags, component masks and a LIFO free-id stack.
// ----------------------------------------------------------------------------
//   channel | dir | content
//   --------+-----+---------------------------------------------------------
//   req     | in  | req_type, entity_id, component_id, query_mask
//   rsp     | out | status, result_id, has_component, match_found,
//           |     | ids_issued, last
//
// Single-entry requests do a memory read, then modify/write/result.
// A query reads id 0 in the accept cycle; each later id takes a read and an
// evaluate state (one read port of the entity memory), and the final result
// comes from S_QEND, which a query with no issued ids enters directly.
// One request is in flight at a time; a result waiting in the output
// register does not block the next request. rsp stalls hold the walk.
// No clearing pass after reset: ids below the fresh-id count are always
// written at create before any read.
// ----------------------------------------------------------------------------
module entity_component_mask_table
  import ecmt_pkg::*;
#(
  parameter int MAX_ENTITIES    = 64,
  parameter int COMPONENT_TYPES = 32
) (
  input  logic         clk,
  input  logic         rst,
  ecmt_req_if.sink     req,
  ecmt_rsp_if.source   rsp
);

  localparam int IDW = $clog2(MAX_ENTITIES);
  localparam int CW  = $clog2(MAX_ENTITIES + 1);
  localparam int CT  = COMPONENT_TYPES;
  localparam int WW  = CT + 1;

  // entity word: {alive, mask}
  logic [WW-1:0]  ent_mem [MAX_ENTITIES];
  logic [IDW-1:0] stk_mem [MAX_ENTITIES];

  logic           ent_we, ent_re;
  logic [IDW-1:0] ent_waddr, ent_raddr;
  logic [WW-1:0]  ent_wdata, ent_rdata;
  logic           stk_we, stk_re;
  logic [IDW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  state_e_t       state, state_next;
  logic [CW-1:0]  free_count, free_count_next;
  logic [CW-1:0]  nfi, nfi_next;
  logic [CW-1:0]  walk_id, walk_id_next;
  logic           pend_valid, pend_valid_next;
  logic [IDW-1:0] pend_id, pend_id_next;

  logic [2:0]     cur_req;
  logic [5:0]     cur_eid;
  logic [4:0]     cur_cid;
  logic [31:0]    cur_qmask;

  logic           out_valid;
  status_e_t      out_status;
  logic [5:0]     out_rid;
  logic           out_has, out_match, out_last;
  logic [6:0]     out_issued;

  logic           out_ok, o_load, o_has, o_match, o_last;
  status_e_t      o_status;
  logic [5:0]     o_rid;

  logic           issued, cid_ok, q_match;
  logic [31:0]    mask_ext, bit32;
  logic [CT-1:0]  bitm;

  assign out_ok   = !out_valid || rsp.ready;
  assign issued   = {1'b0, cur_eid} < 7'(nfi);
  assign cid_ok   = {1'b0, cur_cid} < 6'(COMPONENT_TYPES);
  assign mask_ext = 32'(ent_rdata[CT-1:0]);
  assign bit32    = 32'(1) << cur_cid;
  assign bitm     = CT'(bit32);
  assign q_match  = ent_rdata[WW-1] && ((mask_ext & cur_qmask) == cur_qmask);

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.result_id     = out_rid;
  assign rsp.has_component = out_has;
  assign rsp.match_found   = out_match;
  assign rsp.ids_issued    = out_issued;
  assign rsp.last          = out_last;

  always_comb begin
    state_next      = state;
    ent_re          = 1'b0;
    ent_raddr       = IDW'(req.entity_id);
    ent_we          = 1'b0;
    ent_waddr       = IDW'(cur_eid);
    ent_wdata       = ent_rdata;
    stk_re          = 1'b0;
    stk_raddr       = IDW'(free_count - CW'(1));
    stk_we          = 1'b0;
    stk_waddr       = IDW'(free_count);
    stk_wdata       = IDW'(cur_eid);
    free_count_next = free_count;
    nfi_next        = nfi;
    walk_id_next    = walk_id;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    o_load          = 1'b0;
    o_status        = ST_OK;
    o_rid           = '0;
    o_has           = 1'b0;
    o_match         = 1'b0;
    o_last          = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          ent_re          = 1'b1;
          stk_re          = 1'b1;
          walk_id_next    = '0;
          pend_valid_next = 1'b0;
          if (req.req_type == REQ_QUERY) begin
            ent_raddr  = '0;
            state_next = (nfi == '0) ? S_QEND : S_QEVAL;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_ok) begin
          o_load     = 1'b1;
          state_next = S_IDLE;
          case (cur_req) inside
            REQ_CREATE: begin
              if (free_count != '0) begin
                free_count_next = free_count - CW'(1);
                ent_we          = 1'b1;
                ent_waddr       = stk_rdata;
                ent_wdata       = {1'b1, {CT{1'b0}}};
                o_rid           = 6'(stk_rdata);
              end else if (nfi != CW'(MAX_ENTITIES)) begin
                nfi_next  = nfi + CW'(1);
                ent_we    = 1'b1;
                ent_waddr = IDW'(nfi);
                ent_wdata = {1'b1, {CT{1'b0}}};
                o_rid     = 6'(nfi);
              end else begin
                o_status = ST_FULL;
              end
            end
            REQ_KILL: begin
              if (!issued) begin
                o_status = ST_BADID;
              end else if (ent_rdata[WW-1]) begin
                ent_we          = 1'b1;
                ent_wdata       = {1'b0, ent_rdata[CT-1:0]};
                stk_we          = 1'b1;
                free_count_next = free_count + CW'(1);
              end
            end
            REQ_ADD, REQ_REMOVE: begin
              if (!issued) begin
                o_status = ST_BADID;
              end else if (cid_ok) begin
                ent_we = 1'b1;
                if (cur_req == REQ_ADD) begin
                  ent_wdata = {ent_rdata[WW-1], ent_rdata[CT-1:0] | bitm};
                end else begin
                  ent_wdata = {ent_rdata[WW-1], ent_rdata[CT-1:0] & ~bitm};
                end
              end
            end
            REQ_HAS: begin
              if (!issued) begin
                o_status = ST_BADID;
              end else begin
                o_has = cid_ok && ((mask_ext & bit32) != '0);
              end
            end
            default: ;
          endcase
        end
      end
      S_QRD: begin
        ent_re     = 1'b1;
        ent_raddr  = IDW'(walk_id);
        state_next = S_QEVAL;
      end
      S_QEVAL: begin
        if (!q_match || !pend_valid || out_ok) begin
          if (q_match) begin
            if (pend_valid) begin
              o_load  = 1'b1;
              o_rid   = 6'(pend_id);
              o_match = 1'b1;
              o_last  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = IDW'(walk_id);
          end
          walk_id_next = walk_id + CW'(1);
          state_next   = (walk_id + CW'(1) == nfi) ? S_QEND : S_QRD;
        end
      end
      S_QEND: begin
        if (out_ok) begin
          o_load     = 1'b1;
          state_next = S_IDLE;
          if (pend_valid) begin
            o_rid   = 6'(pend_id);
            o_match = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      nfi        <= '0;
      walk_id    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      nfi        <= nfi_next;
      walk_id    <= walk_id_next;
      pend_valid <= pend_valid_next;
      if (o_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_id <= pend_id_next;
    if (req.valid && req.ready) begin
      cur_req   <= req.req_type;
      cur_eid   <= req.entity_id;
      cur_cid   <= req.component_id;
      cur_qmask <= req.query_mask;
    end
    if (o_load) begin
      out_status <= o_status;
      out_rid    <= o_rid;
      out_has    <= o_has;
      out_match  <= o_match;
      out_last   <= o_last;
      out_issued <= 7'(nfi_next);
    end
  end

  a_free_le_issued: assert property (@(posedge clk) disable iff (rst)
    free_count <= nfi)
    else $error("free stack deeper than issued ids");

  a_nfi_range: assert property (@(posedge clk) disable iff (rst)
    nfi <= CW'(MAX_ENTITIES))
    else $error("fresh id count beyond table size");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item taken while one is in flight");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && out_ok) |=> (state == S_IDLE && out_valid))
    else $error("single-entry request did not complete");

  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_match) |-> (out_status == ST_OK && !out_has))
    else $error("query match with bad status");

endmodule

// ----- verif/ecmt_checker.sv -----
// ----------------------------------------------------------------------------
// ecmt_checker
// Watches the request and result channels of the entity component mask
// table. Keeps its own copy of the id table (alive flags, masks, free-id
// stack, fresh-id count) and predicts the results of every accepted request.
// Each accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ecmt_checker
  import ecmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ecmt_req_if  req,
  ecmt_rsp_if  rsp,
  output int   mismatches,
  output int   outstanding,
  output int   rsp_seen,
  output int   match_seen,
  output int   full_seen,
  output int   badid_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] result_id;
    logic       has_component;
    logic       match_found;
    logic [6:0] ids_issued;
    logic       last;
  } ecmt_rsp_t;

  logic        alive_q   [64];
  logic [31:0] comp_mask [64];
  logic [5:0]  free_ids  [64];
  int unsigned free_depth;
  int unsigned fresh_ids;
  ecmt_rsp_t   rsp_fifo[$];

  function automatic void push_rsp(logic [1:0] st, logic [5:0] rid, logic hc, logic mf,
                                   logic lst);
    ecmt_rsp_t r;
    r.status        = st;
    r.result_id     = rid;
    r.has_component = hc;
    r.match_found   = mf;
    r.ids_issued    = fresh_ids[6:0];
    r.last          = lst;
    rsp_fifo.push_back(r);
  endfunction

  function automatic void apply_request(logic [2:0] op, logic [5:0] eid, logic [4:0] cid,
                                        logic [31:0] qmask);
    logic      issued;
    logic [5:0] id;
    int        hits;
    int        i;
    issued = eid < fresh_ids;
    hits   = 0;
    case (op) inside
      REQ_CREATE: begin
        if (free_depth > 0) begin
          free_depth--;
          id = free_ids[free_depth];
        end else if (fresh_ids < 64) begin
          id = fresh_ids[5:0];
          fresh_ids++;
        end else begin
          push_rsp(ST_FULL, 6'd0, 1'b0, 1'b0, 1'b1);
          return;
        end
        alive_q[id]   = 1'b1;
        comp_mask[id] = '0;
        push_rsp(ST_OK, id, 1'b0, 1'b0, 1'b1);
      end
      REQ_KILL: begin
        if (!issued) begin
          push_rsp(ST_BADID, 6'd0, 1'b0, 1'b0, 1'b1);
        end else begin
          // already dead: no second push
          if (alive_q[eid] && free_depth < 64) begin
            alive_q[eid]         = 1'b0;
            free_ids[free_depth] = eid;
            free_depth++;
          end
          push_rsp(ST_OK, 6'd0, 1'b0, 1'b0, 1'b1);
        end
      end
      REQ_ADD, REQ_REMOVE: begin
        if (!issued) begin
          push_rsp(ST_BADID, 6'd0, 1'b0, 1'b0, 1'b1);
        end else begin
          if (op == REQ_ADD) begin
            comp_mask[eid][cid] = 1'b1;
          end else begin
            comp_mask[eid][cid] = 1'b0;
          end
          push_rsp(ST_OK, 6'd0, 1'b0, 1'b0, 1'b1);
        end
      end
      REQ_HAS: begin
        if (!issued) begin
          push_rsp(ST_BADID, 6'd0, 1'b0, 1'b0, 1'b1);
        end else begin
          push_rsp(ST_OK, 6'd0, comp_mask[eid][cid], 1'b0, 1'b1);
        end
      end
      REQ_QUERY: begin
        for (i = 0; i < fresh_ids; i++) begin
          if (alive_q[i] && (comp_mask[i] & qmask) == qmask) begin
            push_rsp(ST_OK, i[5:0], 1'b0, 1'b1, 1'b0);
            hits++;
          end
        end
        if (hits == 0) begin
          push_rsp(ST_OK, 6'd0, 1'b0, 1'b0, 1'b1);
        end else begin
          rsp_fifo[rsp_fifo.size() - 1].last = 1'b1;
        end
      end
      default: begin
        push_rsp(ST_OK, 6'd0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    ecmt_rsp_t got;
    ecmt_rsp_t want;
    int        i;
    if (rst) begin
      for (i = 0; i < 64; i++) begin
        alive_q[i]   = 1'b0;
        comp_mask[i] = '0;
        free_ids[i]  = '0;
      end
      free_depth  = 0;
      fresh_ids   = 0;
      rsp_fifo.delete();
      mismatches  = 0;
      outstanding = 0;
      rsp_seen    = 0;
      match_seen  = 0;
      full_seen   = 0;
      badid_seen  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.status        = rsp.status;
        got.result_id     = rsp.result_id;
        got.has_component = rsp.has_component;
        got.match_found   = rsp.match_found;
        got.ids_issued    = rsp.ids_issued;
        got.last          = rsp.last;
        rsp_seen++;
        if (rsp_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result item with none pending: status %0d id %0d last %0d",
                     $time, got.status, got.result_id, got.last);
          end
        end else begin
          want = rsp_fifo.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch (expected/actual)", $time);
              $display("  status %0d/%0d id %0d/%0d has %0d/%0d match %0d/%0d",
                       want.status, got.status, want.result_id, got.result_id,
                       want.has_component, got.has_component,
                       want.match_found, got.match_found);
              $display("  ids_issued %0d/%0d last %0d/%0d",
                       want.ids_issued, got.ids_issued, want.last, got.last);
            end
          end
          if (want.match_found) match_seen++;
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_BADID) badid_seen++;
        end
      end
      if (req.valid && req.ready) begin
        apply_request(req.req_type, req.entity_id, req.component_id, req.query_mask);
      end
      outstanding = rsp_fifo.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the entity component mask table. A directed
// sequence covers bad ids, repeated kill, dead ids, id reuse and query
// corners; random mixes and a create burst that fills the table follow.
// Both channels idle at random; ecmt_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top
  import ecmt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MIX_ITEMS    = 14;
  localparam int FILL_CREATES = 66;

  logic clk;
  logic rst;
  bit   no_idle;
  int   items_sent;
  int   creates_sent;
  int   cycles = 0;
  int   mismatches;
  int   outstanding;
  int   rsp_seen;
  int   match_seen;
  int   full_seen;
  int   badid_seen;

  ecmt_req_if req_ch ();
  ecmt_rsp_if rsp_ch ();

  entity_component_mask_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ecmt_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .rsp_seen    (rsp_seen),
    .match_seen  (match_seen),
    .full_seen   (full_seen),
    .badid_seen  (badid_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(logic [2:0] op, logic [5:0] eid, logic [4:0] cid,
                          logic [31:0] qmask);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= op;
    req_ch.entity_id    <= eid;
    req_ch.component_id <= cid;
    req_ch.query_mask   <= qmask;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    if (op == REQ_CREATE) creates_sent++;
  endtask

  task automatic random_mix(int count);
    int          kind;
    int          top_id;
    logic [2:0]  op;
    logic [5:0]  eid;
    logic [4:0]  cid;
    logic [31:0] qmask;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 24)      op = REQ_CREATE;
      else if (kind < 36) op = REQ_KILL;
      else if (kind < 56) op = REQ_ADD;
      else if (kind < 68) op = REQ_REMOVE;
      else if (kind < 82) op = REQ_HAS;
      else if (kind < 96) op = REQ_QUERY;
      else                op = 3'($urandom_range(6, 7));
      // creates sent bound the issued ids; the top one may be unissued
      top_id = (creates_sent > 63) ? 63 : creates_sent;
      eid = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, top_id));
      cid = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                        : 5'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0:       qmask = '0;
        1:       qmask = 32'd1 << $urandom_range(0, 31);
        2:       qmask = $urandom;
        default: qmask = $urandom_range(0, 15);
      endcase
      send_req(op, eid, cid, qmask);
    end
  endtask

  initial begin
    int run;
    int gap;
    rsp_ch.ready <= 1'b1;
    forever begin
      run = $urandom_range(1, 24);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("** entity_component_mask_table: FAILED **");
      $finish;
    end
  end

  initial begin
    no_idle      = 1'b0;
    items_sent   = 0;
    creates_sent = 0;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= '0;
    req_ch.entity_id    <= '0;
    req_ch.component_id <= '0;
    req_ch.query_mask   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table: bad ids, empty query, unknown codes
    send_req(REQ_HAS, 6'd0, 5'd0, 32'd0);
    send_req(REQ_KILL, 6'd63, 5'd31, 32'hFFFF_FFFF);
    send_req(REQ_QUERY, 6'd0, 5'd0, 32'd0);
    send_req(3'd6, 6'd63, 5'd31, 32'hFFFF_FFFF);
    send_req(3'd7, 6'd21, 5'd10, 32'h5A5A_A5A5);
    send_req(REQ_CREATE, 6'd63, 5'd31, 32'hFFFF_FFFF);
    send_req(REQ_CREATE, 6'd0, 5'd0, 32'd0);
    send_req(REQ_CREATE, 6'd42, 5'd17, 32'h1234_5678);
    send_req(REQ_ADD, 6'd0, 5'd0, 32'd0);
    send_req(REQ_ADD, 6'd0, 5'd31, 32'd0);
    send_req(REQ_ADD, 6'd1, 5'd31, 32'd0);
    send_req(REQ_HAS, 6'd0, 5'd31, 32'd0);
    send_req(REQ_HAS, 6'd2, 5'd31, 32'd0);
    send_req(REQ_QUERY, 6'd0, 5'd0, 32'h8000_0000);
    send_req(REQ_QUERY, 6'd0, 5'd0, 32'hFFFF_FFFF);
    send_req(REQ_QUERY, 6'd0, 5'd0, 32'd0);
    send_req(REQ_REMOVE, 6'd0, 5'd31, 32'd0);
    send_req(REQ_ADD, 6'd3, 5'd5, 32'd0);
    // kill twice, then touch the dead id and reuse it
    send_req(REQ_KILL, 6'd1, 5'd0, 32'd0);
    send_req(REQ_KILL, 6'd1, 5'd0, 32'd0);
    send_req(REQ_ADD, 6'd1, 5'd7, 32'd0);
    send_req(REQ_HAS, 6'd1, 5'd7, 32'd0);
    send_req(REQ_QUERY, 6'd0, 5'd0, 32'h0000_0080);
    send_req(REQ_CREATE, 6'd0, 5'd0, 32'd0);
    send_req(REQ_HAS, 6'd1, 5'd7, 32'd0);
    send_req(REQ_REMOVE, 6'd63, 5'd0, 32'd0);

    random_mix(MIX_ITEMS);
    // fill the table past full; first half back to back
    no_idle = 1'b1;
    repeat (FILL_CREATES / 2) send_req(REQ_CREATE, 6'($urandom), 5'($urandom), $urandom);
    no_idle = 1'b0;
    repeat (FILL_CREATES - FILL_CREATES / 2)
      send_req(REQ_CREATE, 6'($urandom), 5'($urandom), $urandom);
    random_mix(MIX_ITEMS);
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d creates), checked %0d result items,", items_sent,
             creates_sent, rsp_seen);
    $display("including %0d query matches, %0d table-full and %0d bad-id results.",
             match_seen, full_seen, badid_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** entity_component_mask_table: PASSED **");
    end else begin
      $display("** entity_component_mask_table: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ecmt_pkg.sv
sv/ecmt_ifs.sv
sv/entity_component_mask_table.sv
verif/ecmt_checker.sv
verif/tb_top.sv
